### rtl/crr_pkg.sv
// Package for the CAN response reassembler: shared types, codes and helpers.
// No dependencies.
`default_nettype none
package crr_pkg;

  localparam logic [15:0] MULTI_HEAD_WORD = 16'hffff;
  localparam logic [15:0] BYTE_LIMIT_RESET = 16'd8;
  localparam logic [6:0] HUNT_LIMIT_RESET = 7'd100;
  localparam logic [7:0] HOST_ADDRESS_RESET = 8'd1;
  localparam logic [2:0] CHUNK_MAX = 3'd6;

  typedef enum logic [2:0] {
    REG_EXPECTED_CODE = 3'd0,
    REG_HOST_ADDRESS  = 3'd1,
    REG_BYTE_LIMIT    = 3'd2,
    REG_HUNT_LIMIT    = 3'd3
  } crr_reg_t;

  typedef enum logic [1:0] {
    OUTCOME_OK        = 2'd0,
    OUTCOME_SYNC_FAIL = 2'd1,
    OUTCOME_PKG_LOST  = 2'd2
  } crr_outcome_t;

  typedef struct packed {
    logic [15:0] expected_code;
    logic [7:0]  host_address;
    logic [15:0] byte_limit;
    logic [6:0]  hunt_limit;
  } crr_cfg_t;

  typedef struct packed {
    logic        collecting;
    logic [6:0]  hunt_count;
    logic [15:0] next_id;
    logic [15:0] byte_total;
    logic [31:0] captured_time;
  } crr_state_t;

  typedef struct packed {
    logic [47:0]  chunk;
    logic [2:0]   chunk_count;
    logic [15:0]  total_bytes;
    crr_outcome_t outcome;
    logic         final_res;
    logic [31:0]  start_time;
  } crr_result_t;

  // keeps the first n bytes of a left-aligned 48-bit chunk
  function automatic logic [47:0] keep_mask(input logic [2:0] n);
    logic [47:0] m;
    m = '0;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < n) begin
        m[47 - 8 * i -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/can_response_reassembler.sv
// CAN response reassembler top level: config registers, frame register, result register.
// A frame is held in the frame register and decoded; a frame that yields a result has
// it registered, raising result_valid. Throughput: one frame per cycle, set by the
// combinational decode between the two registers; stalls only on result_stall.
// Reset (rst, synchronous): config to defaults, hunting with zero counts, no result pending.
// Depends on crr_pkg and crr_step.
`default_nettype none
module can_response_reassembler import crr_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         frame_valid,
  output logic        frame_stall,
  input  wire  [63:0] frame_bytes,
  input  wire  [31:0] frame_time,
  output logic        result_valid,
  input  wire         result_stall,
  output logic [47:0] chunk,
  output logic [2:0]  chunk_count,
  output logic [15:0] total_bytes,
  output logic [1:0]  outcome,
  output logic        final_res,
  output logic [31:0] start_time,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  crr_cfg_t    cfg;
  crr_state_t  state;
  crr_state_t  state_next;
  crr_result_t step_result;
  crr_result_t result;
  logic        step_fire;
  logic        hold_valid;
  logic [63:0] hold_frame;
  logic [31:0] hold_time;
  logic        advance;
  logic        frame_take;

  assign cfg_ready  = 1'b1;
  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign frame_stall = hold_valid && !advance;
  assign frame_take = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_code <= '0;
      cfg.host_address  <= HOST_ADDRESS_RESET;
      cfg.byte_limit    <= BYTE_LIMIT_RESET;
      cfg.hunt_limit    <= HUNT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPECTED_CODE: cfg.expected_code <= cfg_data;
        REG_HOST_ADDRESS:  cfg.host_address  <= cfg_data[7:0];
        REG_BYTE_LIMIT:    cfg.byte_limit    <= cfg_data;
        REG_HUNT_LIMIT:    cfg.hunt_limit    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frame_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      hold_frame <= frame_bytes;
      hold_time  <= frame_time;
    end
  end

  crr_step u_step (
    .cfg         (cfg),
    .state       (state),
    .frame_bytes (hold_frame),
    .frame_time  (hold_time),
    .state_next  (state_next),
    .result      (step_result),
    .fire        (step_fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && step_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_fire) begin
      result <= step_result;
    end
  end

  assign chunk       = result.chunk;
  assign chunk_count = result.chunk_count;
  assign total_bytes = result.total_bytes;
  assign outcome     = result.outcome;
  assign final_res   = result.final_res;
  assign start_time  = result.start_time;

  a_collect_clears_hunt: assert property (@(posedge clk) disable iff (rst)
    state.collecting |-> (state.hunt_count == 7'd0))
    else $error("hunt count nonzero while collecting");

  a_sync_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.outcome == OUTCOME_SYNC_FAIL))
      |-> (result.chunk_count == 3'd0 && result.final_res && result.total_bytes == 16'd0))
    else $error("sync failure result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.chunk_count <= CHUNK_MAX))
    else $error("chunk count above six");

  a_stall_means_held: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (hold_valid && result_valid && result_stall))
    else $error("frame stalled with free result slot");

endmodule
`default_nettype wire

### rtl/crr_step.sv
// Frame decode and state update for one received CAN frame.
// Depends on crr_pkg.
`default_nettype none
module crr_step import crr_pkg::*; (
  input  wire crr_cfg_t    cfg,
  input  wire crr_state_t  state,
  input  wire [63:0]       frame_bytes,
  input  wire [31:0]       frame_time,
  output crr_state_t       state_next,
  output crr_result_t      result,
  output logic             fire
);

  logic [15:0] w0;
  logic        is_head;
  logic        is_single;
  logic [15:0] head_id;
  logic [1:0]  single_n;
  logic [6:0]  hunt_inc;
  logic [6:0]  hunt_lim;
  logic [15:0] room;
  logic [2:0]  take_n;
  logic [15:0] total_sum;
  logic [15:0] id_dec;

  assign w0        = frame_bytes[63:48];
  assign head_id   = frame_bytes[47:32];
  assign is_head   = (w0 == MULTI_HEAD_WORD) && (frame_bytes[15:0] == cfg.expected_code)
                     && (frame_bytes[23:16] == cfg.host_address);
  assign is_single = (w0 == 16'd0) && (frame_bytes[31:16] == cfg.expected_code)
                     && (frame_bytes[39:32] == cfg.host_address);
  assign single_n  = (cfg.byte_limit[15:1] == 15'd0) ? {1'b0, cfg.byte_limit[0]} : 2'd2;
  assign hunt_inc  = state.hunt_count + 7'd1;
  assign hunt_lim  = (cfg.hunt_limit == 7'd0) ? 7'd1 : cfg.hunt_limit;
  assign room      = (cfg.byte_limit > state.byte_total) ?
                     (cfg.byte_limit - state.byte_total) : 16'd1;
  assign take_n    = (room < {13'd0, CHUNK_MAX}) ? room[2:0] : CHUNK_MAX;
  assign total_sum = state.byte_total + {13'd0, take_n};
  assign id_dec    = state.next_id - 16'd1;

  always_comb begin
    state_next = state;
    result     = '0;
    result.outcome = OUTCOME_OK;
    fire       = 1'b0;
    if (!state.collecting) begin
      priority if (is_head) begin
        state_next.hunt_count    = '0;
        state_next.captured_time = frame_time;
        state_next.byte_total    = '0;
        if (head_id <= 16'd1) begin
          fire              = 1'b1;
          result.final_res  = 1'b1;
          result.start_time = frame_time;
        end else begin
          state_next.next_id    = head_id - 16'd1;
          state_next.collecting = 1'b1;
        end
      end else if (is_single) begin
        state_next.hunt_count    = '0;
        state_next.captured_time = frame_time;
        state_next.byte_total    = {14'd0, single_n};
        fire               = 1'b1;
        result.chunk       = {frame_bytes[15:0], 32'd0} & keep_mask({1'b0, single_n});
        result.chunk_count = {1'b0, single_n};
        result.total_bytes = {14'd0, single_n};
        result.final_res   = 1'b1;
        result.start_time  = frame_time;
      end else begin
        if (hunt_inc >= hunt_lim) begin
          state_next.hunt_count = '0;
          fire             = 1'b1;
          result.outcome   = OUTCOME_SYNC_FAIL;
          result.final_res = 1'b1;
        end else begin
          state_next.hunt_count = hunt_inc;
        end
      end
    end else if (w0 != state.next_id) begin
      state_next.collecting = 1'b0;
      state_next.hunt_count = '0;
      fire               = 1'b1;
      result.total_bytes = state.byte_total;
      result.outcome     = OUTCOME_PKG_LOST;
      result.final_res   = 1'b1;
      result.start_time  = state.captured_time;
    end else begin
      state_next.byte_total = total_sum;
      fire               = 1'b1;
      result.chunk       = frame_bytes[47:0] & keep_mask(take_n);
      result.chunk_count = take_n;
      result.total_bytes = total_sum;
      result.start_time  = state.captured_time;
      if (total_sum >= cfg.byte_limit) begin
        result.final_res = 1'b1;
      end else begin
        state_next.next_id = id_dec;
        result.final_res   = (id_dec == 16'd0);
      end
      if (result.final_res) begin
        state_next.collecting = 1'b0;
        state_next.hunt_count = '0;
      end
    end
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for can_response_reassembler: directed table, then random phases.
// Results come from an in-bench reassembly model or the table and are checked field by field.
// Depends on crr_pkg and the can_response_reassembler RTL.
`timescale 1ns / 1ps
module tb_top import crr_pkg::*; ();

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_FRAMES  = 200;
  localparam logic [2:0] UNUSED_REG = 3'd7;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] bytes;
    logic [31:0] stamp;
    bit          typed;
    crr_result_t want;
    logic [2:0]  idx;
    logic [15:0] val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_valid = 1'b0;
  logic        frame_stall;
  logic [63:0] frame_bytes = '0;
  logic [31:0] frame_time = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [47:0] chunk;
  logic [2:0]  chunk_count;
  logic [15:0] total_bytes;
  logic [1:0]  outcome;
  logic        final_res;
  logic [31:0] start_time;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // configuration copy
  logic [15:0] code_r = 16'h0000;
  logic [7:0]  host_r = HOST_ADDRESS_RESET;
  logic [15:0] blim_r = BYTE_LIMIT_RESET;
  logic [6:0]  hlim_r = HUNT_LIMIT_RESET;

  // reassembly state copy
  bit          collecting_m = 1'b0;
  logic [6:0]  hunt_m = '0;
  logic [15:0] next_id_m = '0;
  logic [15:0] total_m = '0;
  logic [31:0] time_m = '0;

  crr_result_t pending_q[$];
  logic [63:0] frame_plan[$];
  row_t        script[$];
  int          err_count = 0;
  int          frames_sent = 0;
  int          steady_left = 0;
  int          cycle_count = 0;

  can_response_reassembler DUT (
    .clk(clk), .rst(rst),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .frame_bytes(frame_bytes), .frame_time(frame_time),
    .result_valid(result_valid), .result_stall(result_stall),
    .chunk(chunk), .chunk_count(chunk_count), .total_bytes(total_bytes),
    .outcome(outcome), .final_res(final_res), .start_time(start_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic flag(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [47:0] lead_bytes(input logic [47:0] c, input int n);
    logic [47:0] m;
    m = '0;
    if (n > 0) m = ~48'h0 << (8 * (6 - n));
    return c & m;
  endfunction

  task automatic reassemble(input logic [63:0] f, input logic [31:0] t,
                            output bit yields, output crr_result_t r);
    logic [15:0] w0;
    logic [15:0] id;
    logic [6:0]  lim;
    int          n;
    int          room;
    bit          fin;
    yields = 1'b0;
    r = '0;
    r.outcome = OUTCOME_OK;
    w0 = f[63:48];
    if (!collecting_m) begin
      if (w0 == MULTI_HEAD_WORD && f[15:0] == code_r && f[23:16] == host_r) begin
        id = f[47:32];
        hunt_m = '0;
        time_m = t;
        total_m = '0;
        if (id <= 16'd1) begin
          yields = 1'b1;
          r.final_res = 1'b1;
          r.start_time = t;
        end else begin
          next_id_m = id - 16'd1;
          collecting_m = 1'b1;
        end
        return;
      end
      if (w0 == 16'h0000 && f[31:16] == code_r && f[39:32] == host_r) begin
        n = (blim_r < 16'd2) ? int'(blim_r) : 2;
        hunt_m = '0;
        time_m = t;
        total_m = 16'(n);
        yields = 1'b1;
        r.chunk = lead_bytes({f[15:0], 32'h0}, n);
        r.chunk_count = 3'(n);
        r.total_bytes = total_m;
        r.final_res = 1'b1;
        r.start_time = t;
        return;
      end
      hunt_m = hunt_m + 7'd1;
      lim = (hlim_r == 7'd0) ? 7'd1 : hlim_r;
      if (hunt_m >= lim) begin
        hunt_m = '0;
        yields = 1'b1;
        r.outcome = OUTCOME_SYNC_FAIL;
        r.final_res = 1'b1;
      end
      return;
    end
    yields = 1'b1;
    if (w0 != next_id_m) begin
      collecting_m = 1'b0;
      hunt_m = '0;
      r.total_bytes = total_m;
      r.outcome = OUTCOME_PKG_LOST;
      r.final_res = 1'b1;
      r.start_time = time_m;
      return;
    end
    room = (int'(blim_r) > int'(total_m)) ? int'(blim_r) - int'(total_m) : 1;
    n = (room < 6) ? room : 6;
    total_m = total_m + 16'(n);
    if (total_m >= blim_r) begin
      fin = 1'b1;
    end else begin
      next_id_m = next_id_m - 16'd1;
      fin = (next_id_m == 16'd0);
    end
    if (fin) begin
      collecting_m = 1'b0;
      hunt_m = '0;
    end
    r.chunk = lead_bytes(f[47:0], n);
    r.chunk_count = 3'(n);
    r.total_bytes = total_m;
    r.final_res = fin;
    r.start_time = time_m;
  endtask

  function automatic int next_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_frame(input logic [63:0] f, input logic [31:0] t,
                            input bit typed, input crr_result_t want);
    bit          yields;
    crr_result_t r;
    int          gap;
    frame_valid <= 1'b1;
    frame_bytes <= f;
    frame_time <= t;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    reassemble(f, t, yields, r);
    if (typed) pending_q.push_back(want);
    else if (yields) pending_q.push_back(r);
    frames_sent++;
    gap = next_gap();
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EXPECTED_CODE: code_r = val;
      REG_HOST_ADDRESS:  host_r = val[7:0];
      REG_BYTE_LIMIT:    blim_r = val;
      REG_HUNT_LIMIT:    hlim_r = val[6:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic settle_idle();
    frame_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] code, input logic [7:0] host,
                           input logic [15:0] blim, input logic [6:0] hunt);
    write_reg(REG_EXPECTED_CODE, code, 1'b0);
    write_reg(REG_HOST_ADDRESS, {8'($urandom), host}, 1'b0);
    write_reg(REG_BYTE_LIMIT, blim, 1'b0);
    write_reg(REG_HUNT_LIMIT, {9'($urandom), hunt}, 1'b1);
  endtask

  // one response attempt, a broken one, or noise
  task automatic plan_episode();
    int          kind;
    int          r;
    int          n_follow;
    logic [15:0] id;
    logic [63:0] f;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      frame_plan.push_back({16'h0000, 8'($urandom), host_r, code_r, 16'($urandom)});
    end else if (kind < 75) begin
      r = $urandom_range(0, 99);
      if (r < 8) id = 16'($urandom_range(0, 1));
      else if (r < 85) id = 16'($urandom_range(2, 9));
      else id = 16'($urandom);
      frame_plan.push_back({MULTI_HEAD_WORD, id, 8'($urandom), host_r, code_r});
      n_follow = (id > 16'd1) ? int'(id) - 1 : 0;
      if (n_follow > 12) n_follow = $urandom_range(1, 12);
      for (int k = 0; k < n_follow; k++) begin
        id = id - 16'd1;
        f = {id, $urandom, 16'($urandom)};
        if ($urandom_range(0, 99) < 6) begin
          f[63:48] = id ^ 16'($urandom_range(1, 65535));
          frame_plan.push_back(f);
          break;
        end
        frame_plan.push_back(f);
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 3);
        case (r)
          0: f = {MULTI_HEAD_WORD, 16'($urandom), 8'($urandom), host_r,
                  code_r ^ 16'($urandom_range(1, 65535))};
          1: f = {16'h0000, 8'($urandom), host_r ^ 8'($urandom_range(1, 255)),
                  code_r, 16'($urandom)};
          default: f = {$urandom, $urandom};
        endcase
        frame_plan.push_back(f);
      end
    end
  endtask

  task automatic check_result(input crr_result_t got, input crr_result_t want);
    if (got.chunk !== want.chunk)
      flag($sformatf("chunk %h, want %h", got.chunk, want.chunk));
    if (got.chunk_count !== want.chunk_count)
      flag($sformatf("chunk_count %0d, want %0d", got.chunk_count, want.chunk_count));
    if (got.total_bytes !== want.total_bytes)
      flag($sformatf("total_bytes %0d, want %0d", got.total_bytes, want.total_bytes));
    if (got.outcome !== want.outcome)
      flag($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
    if (got.final_res !== want.final_res)
      flag($sformatf("final_res %0b, want %0b", got.final_res, want.final_res));
    if (got.start_time !== want.start_time)
      flag($sformatf("start_time %h, want %h", got.start_time, want.start_time));
  endtask

  always @(posedge clk) begin : result_monitor
    crr_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.chunk = chunk;
      got.chunk_count = chunk_count;
      got.total_bytes = total_bytes;
      got.outcome = crr_outcome_t'(outcome);
      got.final_res = final_res;
      got.start_time = start_time;
      if (pending_q.size() == 0) flag("result with no request pending");
      else check_result(got, pending_q.pop_front());
    end
  end

  // receiver: random stall runs, quiet stretches, one long hold-off
  initial begin : receiver
    bit held_long;
    int mode;
    held_long = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && frames_sent >= 700) begin
        held_long = 1'b1;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (mode < 5) begin
          result_stall <= 1'b1;
          if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 40)) @(posedge clk);
          else repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
      end
    end
  end

  function automatic row_t frame_row(input logic [63:0] f, input logic [31:0] t);
    row_t r;
    r = '{kind: ROW_FRAME, bytes: f, stamp: t, typed: 1'b0, want: '0, idx: '0, val: '0};
    return r;
  endfunction

  function automatic row_t typed_row(input logic [63:0] f, input logic [31:0] t,
                                     input crr_result_t want);
    row_t r;
    r = frame_row(f, t);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t write_row(input logic [2:0] idx, input logic [15:0] val);
    row_t r;
    r = frame_row('0, '0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  initial begin : stimulus
    bit last;
    int sent_in_phase;
    logic [15:0] blim;
    logic [6:0]  hunt;

    // single start, multi head with countdown, heads with id 1 and 0, lost package
    script.push_back(typed_row(64'h0000_0001_0000_ABCD, 32'hFFFF_FFFF,
                     crr_result_t'{48'hABCD_0000_0000, 3'd2, 16'd2, OUTCOME_OK, 1'b1,
                                   32'hFFFF_FFFF}));
    script.push_back(frame_row(64'hFFFF_0003_0001_0000, 32'h0000_0000));
    script.push_back(frame_row(64'h0002_1122_3344_5566, 32'h0000_0005));
    script.push_back(frame_row(64'h0001_7788_99AA_BBCC, 32'h0000_0006));
    script.push_back(typed_row(64'hFFFF_0001_0001_0000, 32'h0000_0007,
                     crr_result_t'{48'h0, 3'd0, 16'd0, OUTCOME_OK, 1'b1, 32'h0000_0007}));
    script.push_back(typed_row(64'hFFFF_0000_0001_0000, 32'h0000_0008,
                     crr_result_t'{48'h0, 3'd0, 16'd0, OUTCOME_OK, 1'b1, 32'h0000_0008}));
    script.push_back(frame_row(64'hFFFF_0003_0001_0000, 32'h0000_0009));
    script.push_back(typed_row(64'h0005_0102_0304_0506, 32'h0000_000A,
                     crr_result_t'{48'h0, 3'd0, 16'd0, OUTCOME_PKG_LOST, 1'b1,
                                   32'h0000_0009}));
    // non-start frames, then sync failure at the smallest hunt limit
    script.push_back(frame_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_000B));
    script.push_back(frame_row(64'h0000_0000_0000_0000, 32'h0000_0000));
    script.push_back(write_row(REG_HUNT_LIMIT, 16'd1));
    script.push_back(typed_row(64'h0000_0000_0000_0000, 32'hFFFF_FFFF,
                     crr_result_t'{48'h0, 3'd0, 16'd0, OUTCOME_SYNC_FAIL, 1'b1, 32'h0}));
    script.push_back(write_row(REG_HUNT_LIMIT, 16'd127));
    script.push_back(write_row(REG_EXPECTED_CODE, 16'hFFFF));
    script.push_back(write_row(REG_HOST_ADDRESS, 16'h00FF));
    script.push_back(write_row(UNUSED_REG, 16'hFFFF));
    script.push_back(frame_row(64'h0000_00FF_FFFF_1234, 32'h0000_0010));
    script.push_back(write_row(REG_BYTE_LIMIT, 16'd1));
    script.push_back(typed_row(64'h0000_00FF_FFFF_5678, 32'h0000_0011,
                     crr_result_t'{48'h5600_0000_0000, 3'd1, 16'd1, OUTCOME_OK, 1'b1,
                                   32'h0000_0011}));
    // largest id, then byte limit lowered under the bytes already taken
    script.push_back(write_row(REG_BYTE_LIMIT, 16'hFFFF));
    script.push_back(frame_row(64'hFFFF_FFFF_00FF_FFFF, 32'h0000_0012));
    script.push_back(frame_row(64'hFFFE_A1A2_A3A4_A5A6, 32'h0000_0013));
    script.push_back(write_row(REG_BYTE_LIMIT, 16'd1));
    script.push_back(frame_row(64'hFFFD_B1B2_B3B4_B5B6, 32'h0000_0014));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i > 0 && script[i - 1].kind == ROW_FRAME) settle_idle();
        last = (i + 1 == script.size()) || (script[i + 1].kind != ROW_WRITE);
        write_reg(script[i].idx, script[i].val, last);
      end else begin
        send_frame(script[i].bytes, script[i].stamp, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      case (p)
        0: write_all(16'h0000, 8'h00, 16'd1, 7'd1);
        1: write_all(16'hFFFF, 8'hFF, 16'hFFFF, 7'd127);
        default: begin
          case ($urandom_range(0, 3))
            0: blim = 16'($urandom_range(1, 8));
            1: blim = 16'($urandom_range(9, 40));
            2: blim = 16'($urandom_range(1, 65535));
            default: blim = 16'hFFFF;
          endcase
          hunt = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 4))
                                             : 7'($urandom_range(1, 127));
          write_all(16'($urandom), 8'($urandom), blim, hunt);
        end
      endcase
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_FRAMES) begin
        plan_episode();
        while (frame_plan.size() != 0) begin
          send_frame(frame_plan.pop_front(), $urandom, 1'b0, '0);
          sent_in_phase++;
        end
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/crr_pkg.sv
rtl/crr_step.sv
rtl/can_response_reassembler.sv
verif/tb_top.sv
